// ===== src/tqc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package tqc_pkg;

  // all three queues share one depth; wrap-around uses the address width
  localparam int Depth = 16;
  localparam int AddrW = $clog2(Depth);
  localparam int CntW  = $clog2(Depth + 1);
  localparam int DataW = 32;
  localparam int LimW  = 5;
  localparam int RegIdxW = 2;

  typedef logic [AddrW-1:0] addr_t;
  typedef logic [CntW-1:0]  cnt_t;
  typedef logic [DataW-1:0] word_t;

  typedef enum logic [2:0] {
    OC_GET_ABSENT  = 3'd0,
    OC_GET_GHOST   = 3'd1,
    OC_GET_MAIN    = 3'd2,
    OC_GET_FIFO    = 3'd3,
    OC_PUT_NEW     = 3'd4,
    OC_PUT_MAIN    = 3'd5,
    OC_PUT_FIFO    = 3'd6,
    OC_PUT_PROMOTE = 3'd7
  } outcome_e;

  localparam logic OP_GET = 1'b0;
  localparam logic OP_PUT = 1'b1;

  localparam logic [RegIdxW-1:0] REG_MAIN_LIMIT  = 2'd0;
  localparam logic [RegIdxW-1:0] REG_ENTRY_LIMIT = 2'd1;
  localparam logic [RegIdxW-1:0] REG_GHOST_LIMIT = 2'd2;

  // clamped limits handed to the core
  typedef struct packed {
    cnt_t main_lim;
    cnt_t entry_lim;
    cnt_t ghost_lim;
  } lim_t;

  typedef struct packed {
    outcome_e outcome;
    logic     hit;
    word_t    read_value;
    logic     evicted;
    word_t    hit_total;
    word_t    miss_total;
    word_t    evict_total;
  } res_t;

endpackage

`default_nettype wire

// ===== src/two_queue_cache_controller_top.sv =====
// Key-value cache with 2Q replacement: a main LRU queue, a FIFO entry queue and
// a ghost key queue, 16 entries each. One get or put item produces one result
// item. A sequencer walks the three queues one entry per cycle; on a promotion
// it then shifts the ghost keys behind the match, searches the main entries for
// the least recent slot when main is full, and places the entry, and on a main
// hit or promotion it updates the recency ranks of the main entries one by one.
// Input is taken only while the sequencer is idle; a finished result waits in an
// output register, and the next item may be accepted while it does. Limits are
// written on the cfg port while idle; a zero main or entry limit acts as one,
// and any limit above 16 acts as 16. No clearing pass is needed after reset.
`timescale 1ns / 1ps
`default_nettype none

module two_queue_cache_controller_top import tqc_pkg::*; (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  // request channel
  input  wire logic                     in_valid_i,
  output logic                          in_ready_o,
  input  wire logic                     opcode_i,
  input  wire logic signed [DataW-1:0]  req_key_i,
  input  wire logic signed [DataW-1:0]  req_value_i,
  // result channel
  output logic                          out_valid_o,
  input  wire logic                     out_ready_i,
  output logic [2:0]                    outcome_o,
  output logic                          hit_o,
  output logic signed [DataW-1:0]       read_value_o,
  output logic                          evicted_o,
  output logic [DataW-1:0]              hit_total_o,
  output logic [DataW-1:0]              miss_total_o,
  output logic [DataW-1:0]              evict_total_o,
  // configuration writes
  input  wire logic                     cfg_we_i,
  input  wire logic [RegIdxW-1:0]       cfg_index_i,
  input  wire logic [LimW-1:0]          cfg_data_i
);

  logic [LimW-1:0] main_limit_q, entry_limit_q, ghost_limit_q;
  lim_t lim;
  logic core_idle, core_done, out_free;
  res_t core_res, res_q;
  logic out_valid_q;

  // limits clamped into the range the queues can hold
  function automatic cnt_t clamp_lim(logic [LimW-1:0] v, logic [LimW-1:0] lo);
    cnt_t r;
    if (v < lo) begin
      r = cnt_t'(lo);
    end else if (v > LimW'(Depth)) begin
      r = cnt_t'(Depth);
    end else begin
      r = cnt_t'(v);
    end
    return r;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_limit_q  <= LimW'(8);
      entry_limit_q <= LimW'(4);
      ghost_limit_q <= LimW'(8);
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_MAIN_LIMIT:  main_limit_q  <= cfg_data_i;
        REG_ENTRY_LIMIT: entry_limit_q <= cfg_data_i;
        REG_GHOST_LIMIT: ghost_limit_q <= cfg_data_i;
        default: ;  // unknown register index is dropped
      endcase
    end
  end

  always_comb begin
    lim.main_lim  = clamp_lim(main_limit_q, LimW'(1));
    lim.entry_lim = clamp_lim(entry_limit_q, LimW'(1));
    lim.ghost_lim = clamp_lim(ghost_limit_q, LimW'(0));
  end

  assign in_ready_o = core_idle;
  // core may hand over a result once the output register empties this cycle
  assign out_free   = !out_valid_q || out_ready_i;

  tqc_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (in_valid_i && core_idle),
    .op_i       (opcode_i),
    .key_i      (word_t'(req_key_i)),
    .val_i      (word_t'(req_value_i)),
    .lim_i      (lim),
    .out_free_i (out_free),
    .idle_o     (core_idle),
    .done_o     (core_done),
    .res_o      (core_res)
  );

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (core_done) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (core_done) begin
      res_q <= core_res;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign outcome_o     = res_q.outcome;
  assign hit_o         = res_q.hit;
  assign read_value_o  = res_q.read_value;
  assign evicted_o     = res_q.evicted;
  assign hit_total_o   = res_q.hit_total;
  assign miss_total_o  = res_q.miss_total;
  assign evict_total_o = res_q.evict_total;

  // an accepted item keeps the sequencer busy next cycle
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("ready right after accept");

  // core never overwrites a result still waiting
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    core_done |-> (!out_valid_q || out_ready_i))
    else $error("result overwritten");

  // hit only on get hits
  a_hit_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && hit_o |-> (res_q.outcome == OC_GET_MAIN || res_q.outcome == OC_GET_FIFO))
    else $error("hit with wrong outcome");

  // evictions only from new puts or promotions
  a_evict_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && evicted_o |->
      (res_q.outcome == OC_PUT_NEW || res_q.outcome == OC_PUT_PROMOTE))
    else $error("eviction with wrong outcome");

endmodule

`default_nettype wire

// ===== src/tqc_core.sv =====
`timescale 1ns / 1ps
`default_nettype none

module tqc_core import tqc_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  start_i,
  input  wire logic  op_i,
  input  wire word_t key_i,
  input  wire word_t val_i,
  input  wire lim_t  lim_i,
  input  wire logic  out_free_i,
  output logic       idle_o,
  output logic       done_o,
  output res_t       res_o
);

  typedef enum logic [9:0] {
    S_IDLE   = 10'b0000000001,
    S_SMAIN  = 10'b0000000010,
    S_SFIFO  = 10'b0000000100,
    S_SGHOST = 10'b0000001000,
    S_ACT    = 10'b0000010000,
    S_GSHIFT = 10'b0000100000,
    S_LRU    = 10'b0001000000,
    S_PLACE  = 10'b0010000000,
    S_TOUCH  = 10'b0100000000,
    S_DONE   = 10'b1000000000
  } state_e;

  state_e   state_q, state_d;
  logic     op_q, op_d;
  word_t    key_q, key_d, val_q, val_d;
  cnt_t     idx_q, idx_d, r_q, r_d;
  addr_t    pos_q, pos_d, slot_q, slot_d;
  logic     fm_q, fm_d, ff_q, ff_d, fg_q, fg_d;
  outcome_e outcome_q, outcome_d;
  logic     hit_q, hit_d, ev_q, ev_d;
  word_t    rv_q, rv_d;
  cnt_t     main_count_q, main_count_d, fifo_count_q, fifo_count_d;
  cnt_t     ghost_count_q, ghost_count_d;
  addr_t    fifo_head_q, fifo_head_d, ghost_head_q, ghost_head_d;
  word_t    hit_cnt_q, hit_cnt_d, miss_cnt_q, miss_cnt_d, evict_cnt_q, evict_cnt_d;

  word_t main_key_q [Depth];
  word_t main_val_q [Depth];
  addr_t main_rec_q [Depth];
  word_t fifo_key_q [Depth];
  word_t fifo_val_q [Depth];
  word_t gq_key_q   [Depth];

  addr_t main_ra, fifo_ra, ghost_ra;
  word_t main_key_rd, main_val_rd, fifo_key_rd, fifo_val_rd, gq_key_rd;
  addr_t main_rec_rd;

  logic  main_kw, main_vw, rec_we, fifo_kw, fifo_vw, ghost_we;
  addr_t main_wa, rec_wa, fifo_wa, ghost_wa, rec_wd;
  word_t main_wkey, main_wval, fifo_wkey, fifo_wval, ghost_wd;

  logic  nf_evict;
  cnt_t  ghost_inc;

  // single read port per store, address picked by the sequencer step
  always_comb begin
    main_ra = pos_q;
    if (state_q == S_SMAIN || state_q == S_LRU || state_q == S_TOUCH) begin
      main_ra = idx_q[AddrW-1:0];
    end
    if (state_q == S_SFIFO) begin
      fifo_ra = fifo_head_q + idx_q[AddrW-1:0];
    end else if (ff_q) begin
      fifo_ra = fifo_head_q + pos_q;
    end else begin
      fifo_ra = fifo_head_q;
    end
    if (state_q == S_SGHOST) begin
      ghost_ra = ghost_head_q + idx_q[AddrW-1:0];
    end else begin
      ghost_ra = ghost_head_q + idx_q[AddrW-1:0] + addr_t'(1);
    end
  end

  assign main_key_rd = main_key_q[main_ra];
  assign main_val_rd = main_val_q[main_ra];
  assign main_rec_rd = main_rec_q[main_ra];
  assign fifo_key_rd = fifo_key_q[fifo_ra];
  assign fifo_val_rd = fifo_val_q[fifo_ra];
  assign gq_key_rd   = gq_key_q[ghost_ra];

  assign nf_evict  = (fifo_count_q >= lim_i.entry_lim) && (fifo_count_q != '0);
  assign ghost_inc = ghost_count_q + cnt_t'(1);

  always_comb begin
    state_d = state_q;
    op_d = op_q; key_d = key_q; val_d = val_q;
    idx_d = idx_q; r_d = r_q; pos_d = pos_q; slot_d = slot_q;
    fm_d = fm_q; ff_d = ff_q; fg_d = fg_q;
    outcome_d = outcome_q; hit_d = hit_q; ev_d = ev_q; rv_d = rv_q;
    main_count_d = main_count_q; fifo_count_d = fifo_count_q;
    ghost_count_d = ghost_count_q;
    fifo_head_d = fifo_head_q; ghost_head_d = ghost_head_q;
    hit_cnt_d = hit_cnt_q; miss_cnt_d = miss_cnt_q; evict_cnt_d = evict_cnt_q;
    main_kw = 1'b0; main_vw = 1'b0; rec_we = 1'b0;
    fifo_kw = 1'b0; fifo_vw = 1'b0; ghost_we = 1'b0;
    main_wa = slot_q; rec_wa = slot_q; rec_wd = '0;
    fifo_wa = fifo_head_q + fifo_count_q[AddrW-1:0];
    ghost_wa = ghost_head_q + idx_q[AddrW-1:0];
    main_wkey = key_q; main_wval = val_q;
    fifo_wkey = key_q; fifo_wval = val_q; ghost_wd = gq_key_rd;
    done_o = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          op_d = op_i; key_d = key_i; val_d = val_i;
          idx_d = '0; fm_d = 1'b0; ff_d = 1'b0; fg_d = 1'b0;
          hit_d = 1'b0; ev_d = 1'b0; rv_d = '0;
          state_d = S_SMAIN;
        end
      end
      S_SMAIN: begin
        if (idx_q < main_count_q) begin
          if (main_key_rd == key_q) begin
            fm_d = 1'b1; pos_d = idx_q[AddrW-1:0]; state_d = S_ACT;
          end else begin
            idx_d = idx_q + cnt_t'(1);
          end
        end else begin
          idx_d = '0; state_d = S_SFIFO;
        end
      end
      S_SFIFO: begin
        if (idx_q < fifo_count_q) begin
          if (fifo_key_rd == key_q) begin
            ff_d = 1'b1; pos_d = idx_q[AddrW-1:0]; state_d = S_ACT;
          end else begin
            idx_d = idx_q + cnt_t'(1);
          end
        end else begin
          idx_d = '0; state_d = S_SGHOST;
        end
      end
      S_SGHOST: begin
        if (idx_q < ghost_count_q) begin
          if (gq_key_rd == key_q) begin
            fg_d = 1'b1; pos_d = idx_q[AddrW-1:0]; state_d = S_ACT;
          end else begin
            idx_d = idx_q + cnt_t'(1);
          end
        end else begin
          state_d = S_ACT;
        end
      end
      S_ACT: begin
        state_d = S_DONE;
        if (fm_q) begin
          outcome_d = (op_q == OP_PUT) ? OC_PUT_MAIN : OC_GET_MAIN;
          if (op_q == OP_PUT) begin
            main_vw = 1'b1; main_wa = pos_q;
          end else begin
            hit_d = 1'b1; rv_d = main_val_rd; hit_cnt_d = hit_cnt_q + word_t'(1);
          end
          r_d = {1'b0, main_rec_rd}; slot_d = pos_q; idx_d = '0;
          state_d = S_TOUCH;
        end else if (ff_q) begin
          outcome_d = (op_q == OP_PUT) ? OC_PUT_FIFO : OC_GET_FIFO;
          if (op_q == OP_PUT) begin
            fifo_vw = 1'b1; fifo_wa = fifo_ra;
          end else begin
            hit_d = 1'b1; rv_d = fifo_val_rd; hit_cnt_d = hit_cnt_q + word_t'(1);
          end
        end else if (op_q == OP_GET) begin
          outcome_d = fg_q ? OC_GET_GHOST : OC_GET_ABSENT;
          miss_cnt_d = miss_cnt_q + word_t'(1);
        end else if (fg_q) begin
          outcome_d = OC_PUT_PROMOTE;
          idx_d = {1'b0, pos_q};
          state_d = S_GSHIFT;
        end else begin
          outcome_d = OC_PUT_NEW;
          fifo_kw = 1'b1; fifo_vw = 1'b1;
          if (nf_evict) begin
            // oldest fifo key leaves and becomes a ghost
            fifo_head_d = fifo_head_q + addr_t'(1);
            ev_d = 1'b1; evict_cnt_d = evict_cnt_q + word_t'(1);
            ghost_we = 1'b1; ghost_wd = fifo_key_rd;
            ghost_wa = ghost_head_q + ghost_count_q[AddrW-1:0];
            if (ghost_count_q == cnt_t'(Depth) || ghost_inc > lim_i.ghost_lim) begin
              ghost_head_d = ghost_head_q + addr_t'(1);
            end
            if (ghost_count_q != cnt_t'(Depth) && ghost_inc <= lim_i.ghost_lim) begin
              ghost_count_d = ghost_inc;
            end
          end else begin
            fifo_count_d = fifo_count_q + cnt_t'(1);
          end
        end
      end
      S_GSHIFT: begin
        if (idx_q + cnt_t'(1) < ghost_count_q) begin
          ghost_we = 1'b1; idx_d = idx_q + cnt_t'(1);
        end else begin
          ghost_count_d = ghost_count_q - cnt_t'(1);
          idx_d = '0;
          if (main_count_q >= lim_i.main_lim && main_count_q != '0) begin
            slot_d = '0; state_d = S_LRU;
          end else begin
            slot_d = main_count_q[AddrW-1:0];
            main_count_d = main_count_q + cnt_t'(1);
            state_d = S_PLACE;
          end
        end
      end
      S_LRU: begin
        if (idx_q < main_count_q) begin
          if ({1'b0, main_rec_rd} == main_count_q - cnt_t'(1)) begin
            slot_d = idx_q[AddrW-1:0];
          end
          idx_d = idx_q + cnt_t'(1);
        end else begin
          ev_d = 1'b1; evict_cnt_d = evict_cnt_q + word_t'(1);
          state_d = S_PLACE;
        end
      end
      S_PLACE: begin
        main_kw = 1'b1; main_vw = 1'b1;
        r_d = main_count_q; idx_d = '0;
        state_d = S_TOUCH;
      end
      S_TOUCH: begin
        if (idx_q < main_count_q) begin
          if ({1'b0, main_rec_rd} < r_q) begin
            rec_we = 1'b1; rec_wa = idx_q[AddrW-1:0];
            rec_wd = main_rec_rd + addr_t'(1);
          end
          idx_d = idx_q + cnt_t'(1);
        end else begin
          rec_we = 1'b1; rec_wa = slot_q; rec_wd = '0;
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free_i) begin
          done_o = 1'b1; state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      fm_q <= 1'b0; ff_q <= 1'b0; fg_q <= 1'b0;
      main_count_q <= '0; fifo_count_q <= '0; ghost_count_q <= '0;
      fifo_head_q <= '0; ghost_head_q <= '0;
      hit_cnt_q <= '0; miss_cnt_q <= '0; evict_cnt_q <= '0;
    end else begin
      state_q <= state_d;
      fm_q <= fm_d; ff_q <= ff_d; fg_q <= fg_d;
      main_count_q <= main_count_d; fifo_count_q <= fifo_count_d;
      ghost_count_q <= ghost_count_d;
      fifo_head_q <= fifo_head_d; ghost_head_q <= ghost_head_d;
      hit_cnt_q <= hit_cnt_d; miss_cnt_q <= miss_cnt_d; evict_cnt_q <= evict_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q <= op_d; key_q <= key_d; val_q <= val_d;
    idx_q <= idx_d; r_q <= r_d; pos_q <= pos_d; slot_q <= slot_d;
    outcome_q <= outcome_d; hit_q <= hit_d; ev_q <= ev_d; rv_q <= rv_d;
    if (main_kw)  main_key_q[main_wa]  <= main_wkey;
    if (main_vw)  main_val_q[main_wa]  <= main_wval;
    if (rec_we)   main_rec_q[rec_wa]   <= rec_wd;
    if (fifo_kw)  fifo_key_q[fifo_wa]  <= fifo_wkey;
    if (fifo_vw)  fifo_val_q[fifo_wa]  <= fifo_wval;
    if (ghost_we) gq_key_q[ghost_wa]   <= ghost_wd;
  end

  assign idle_o = (state_q == S_IDLE);

  always_comb begin
    res_o.outcome     = outcome_q;
    res_o.hit         = hit_q;
    res_o.read_value  = rv_q;
    res_o.evicted     = ev_q;
    res_o.hit_total   = hit_cnt_q;
    res_o.miss_total  = miss_cnt_q;
    res_o.evict_total = evict_cnt_q;
  end

endmodule

`default_nettype wire

// ===== sim/tqc_checker.sv =====
`timescale 1ns / 1ps

module tqc_checker import tqc_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  input  logic                    in_ready_i,
  input  logic                    opcode_i,
  input  logic [DataW-1:0]        req_key_i,
  input  logic [DataW-1:0]        req_value_i,
  input  logic                    out_valid_i,
  input  logic                    out_ready_i,
  input  logic [2:0]              outcome_i,
  input  logic                    hit_i,
  input  logic [DataW-1:0]        read_value_i,
  input  logic                    evicted_i,
  input  logic [DataW-1:0]        hit_total_i,
  input  logic [DataW-1:0]        miss_total_i,
  input  logic [DataW-1:0]        evict_total_i,
  input  logic                    cfg_we_i,
  input  logic [RegIdxW-1:0]      cfg_index_i,
  input  logic [LimW-1:0]         cfg_data_i,
  output int                      fail_count_o,
  output int                      pending_o
);

  logic [LimW-1:0] main_lim, entry_lim, ghost_lim;
  word_t main_key [Depth];
  word_t main_val [Depth];
  int    main_rank [Depth];
  int    main_cnt;
  word_t fifo_key [Depth];
  word_t fifo_val [Depth];
  int    fifo_head, fifo_cnt;
  word_t gq_key [Depth];
  int    ghost_head, ghost_cnt;
  word_t hits, misses, evicts;

  res_t  pending_results [$];

  function automatic int clamp_lim(int v, int lo);
    if (v < lo) return lo;
    if (v > Depth) return Depth;
    return v;
  endfunction

  // slot becomes most recent, younger entries age by one
  function automatic void touch_main(int slot);
    int r;
    r = main_rank[slot];
    for (int i = 0; i < main_cnt; i++)
      if (main_rank[i] < r) main_rank[i]++;
    main_rank[slot] = 0;
  endfunction

  function automatic void drop_oldest_ghost();
    if (ghost_cnt == 0) return;
    ghost_head = (ghost_head + 1) % Depth;
    ghost_cnt--;
  endfunction

  function automatic void push_ghost(word_t key);
    int lim;
    lim = clamp_lim(int'(ghost_lim), 0);
    if (ghost_cnt >= Depth) begin
      drop_oldest_ghost();
      gq_key[(ghost_head + ghost_cnt) % Depth] = key;
      ghost_cnt++;
      return;
    end
    gq_key[(ghost_head + ghost_cnt) % Depth] = key;
    ghost_cnt++;
    if (ghost_cnt > lim) drop_oldest_ghost();
  endfunction

  function automatic logic insert_fifo(word_t key, word_t val);
    int lim;
    logic ev;
    ev = 1'b0;
    lim = clamp_lim(int'(entry_lim), 1);
    if (fifo_cnt >= lim && fifo_cnt > 0) begin
      word_t old;
      old = fifo_key[fifo_head];
      fifo_head = (fifo_head + 1) % Depth;
      fifo_cnt--;
      evicts++;
      ev = 1'b1;
      push_ghost(old);
    end
    fifo_key[(fifo_head + fifo_cnt) % Depth] = key;
    fifo_val[(fifo_head + fifo_cnt) % Depth] = val;
    fifo_cnt++;
    return ev;
  endfunction

  function automatic logic promote_ghost(int off, word_t key, word_t val);
    int lim, slot;
    logic ev;
    ev = 1'b0;
    lim = clamp_lim(int'(main_lim), 1);
    for (int o = off; o + 1 < ghost_cnt; o++)
      gq_key[(ghost_head + o) % Depth] = gq_key[(ghost_head + o + 1) % Depth];
    ghost_cnt--;
    if (main_cnt >= lim && main_cnt > 0) begin
      // replace the least recent main entry
      slot = 0;
      for (int i = 0; i < main_cnt; i++)
        if (main_rank[i] == main_cnt - 1) slot = i;
      evicts++;
      ev = 1'b1;
    end else begin
      slot = main_cnt;
      main_cnt++;
    end
    main_key[slot] = key;
    main_val[slot] = val;
    main_rank[slot] = main_cnt;
    touch_main(slot);
    return ev;
  endfunction

  function automatic res_t cache_lookup(logic op, word_t key, word_t val);
    res_t r;
    int m, f, g, fi;
    r = '0;
    m = -1;
    f = -1;
    g = -1;
    for (int i = 0; i < main_cnt; i++)
      if (m < 0 && main_key[i] == key) m = i;
    if (m < 0)
      for (int o = 0; o < fifo_cnt; o++)
        if (f < 0 && fifo_key[(fifo_head + o) % Depth] == key) f = o;
    if (m < 0 && f < 0)
      for (int o = 0; o < ghost_cnt; o++)
        if (g < 0 && gq_key[(ghost_head + o) % Depth] == key) g = o;
    fi = (fifo_head + f) % Depth;
    if (op == OP_GET) begin
      if (m >= 0) begin
        r.outcome = OC_GET_MAIN;
        r.hit = 1'b1;
        r.read_value = main_val[m];
        touch_main(m);
        hits++;
      end else if (f >= 0) begin
        r.outcome = OC_GET_FIFO;
        r.hit = 1'b1;
        r.read_value = fifo_val[fi];
        hits++;
      end else begin
        r.outcome = (g >= 0) ? OC_GET_GHOST : OC_GET_ABSENT;
        misses++;
      end
    end else begin
      if (m >= 0) begin
        r.outcome = OC_PUT_MAIN;
        main_val[m] = val;
        touch_main(m);
      end else if (f >= 0) begin
        r.outcome = OC_PUT_FIFO;
        fifo_val[fi] = val;
      end else if (g >= 0) begin
        r.outcome = OC_PUT_PROMOTE;
        r.evicted = promote_ghost(g, key, val);
      end else begin
        r.outcome = OC_PUT_NEW;
        r.evicted = insert_fifo(key, val);
      end
    end
    r.hit_total = hits;
    r.miss_total = misses;
    r.evict_total = evicts;
    return r;
  endfunction

  task automatic check_field(string name, logic [DataW-1:0] exp_v, logic [DataW-1:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
      fail_count_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_lim = 5'd8;
      entry_lim = 5'd4;
      ghost_lim = 5'd8;
      main_cnt = 0;
      fifo_head = 0;
      fifo_cnt = 0;
      ghost_head = 0;
      ghost_cnt = 0;
      hits = '0;
      misses = '0;
      evicts = '0;
      pending_results.delete();
      pending_o = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_MAIN_LIMIT:  main_lim = cfg_data_i;
          REG_ENTRY_LIMIT: entry_lim = cfg_data_i;
          REG_GHOST_LIMIT: ghost_lim = cfg_data_i;
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i)
        pending_results.push_back(cache_lookup(opcode_i, req_key_i, req_value_i));
      if (out_valid_i && out_ready_i) begin
        if (pending_results.size() == 0) begin
          $display("%0t: result item with nothing expected, outcome %0d", $time, outcome_i);
          fail_count_o++;
        end else begin
          res_t e;
          e = pending_results.pop_front();
          check_field("outcome", 32'(e.outcome), 32'(outcome_i));
          check_field("hit", 32'(e.hit), 32'(hit_i));
          check_field("read_value", e.read_value, read_value_i);
          check_field("evicted", 32'(e.evicted), 32'(evicted_i));
          check_field("hit_total", e.hit_total, hit_total_i);
          check_field("miss_total", e.miss_total, miss_total_i);
          check_field("evict_total", e.evict_total, evict_total_i);
        end
      end
      pending_o = pending_results.size();
    end
  end

  initial fail_count_o = 0;

endmodule

// ===== sim/tb_two_queue_cache_controller_top.sv =====
`timescale 1ns / 1ps

module tb_two_queue_cache_controller_top;
  import tqc_pkg::*;

  // index past the last register, writes there must be ignored
  localparam logic [RegIdxW-1:0] REG_SPARE = 2'd3;
  localparam int CycleLimit = 1000000;
  localparam int DrainCycles = 120;
  localparam int KeyPool = 40;

  logic clk_i, rst_ni;
  logic in_valid, in_ready, opcode;
  logic [DataW-1:0] req_key, req_value;
  logic out_valid, out_ready;
  logic [2:0] outcome;
  logic hit, evicted;
  logic [DataW-1:0] read_value, hit_total, miss_total, evict_total;
  logic cfg_we;
  logic [RegIdxW-1:0] cfg_index;
  logic [LimW-1:0] cfg_data;

  int fail_count, pending;
  int cycles;
  bit hold_req;
  word_t keys [KeyPool];

  two_queue_cache_controller_top u_top (
    .clk_i, .rst_ni,
    .in_valid_i(in_valid), .in_ready_o(in_ready), .opcode_i(opcode),
    .req_key_i(req_key), .req_value_i(req_value),
    .out_valid_o(out_valid), .out_ready_i(out_ready),
    .outcome_o(outcome), .hit_o(hit), .read_value_o(read_value), .evicted_o(evicted),
    .hit_total_o(hit_total), .miss_total_o(miss_total), .evict_total_o(evict_total),
    .cfg_we_i(cfg_we), .cfg_index_i(cfg_index), .cfg_data_i(cfg_data)
  );

  // checker watches both channels and the register port
  tqc_checker u_checker (
    .clk_i, .rst_ni,
    .in_valid_i(in_valid), .in_ready_i(in_ready), .opcode_i(opcode),
    .req_key_i(req_key), .req_value_i(req_value),
    .out_valid_i(out_valid), .out_ready_i(out_ready),
    .outcome_i(outcome), .hit_i(hit), .read_value_i(read_value), .evicted_i(evicted),
    .hit_total_i(hit_total), .miss_total_i(miss_total), .evict_total_i(evict_total),
    .cfg_we_i(cfg_we), .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // watchdog
  initial cycles = 0;
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // mostly no gap, sometimes a short one, rarely a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // receiver side: random stalls plus one long hold-off on request
  initial begin
    int g;
    out_ready <= 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        out_ready <= 1'b0;
        hold_req = 1'b0;
        repeat (400) @(negedge clk_i);
        out_ready <= 1'b1;
      end else begin
        g = pick_gap();
        if (g > 0) begin
          out_ready <= 1'b0;
          repeat (g) @(negedge clk_i);
        end
        out_ready <= 1'b1;
        repeat ($urandom_range(0, 8)) @(negedge clk_i);
      end
    end
  end

  // one item on the request channel; valid stays up across back-to-back items
  task automatic send_item(logic op, word_t key, word_t val);
    int g;
    g = pick_gap();
    if (g > 0) begin
      @(negedge clk_i);
      in_valid <= 1'b0;
      repeat (g - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid <= 1'b1;
    opcode <= op;
    req_key <= key;
    req_value <= val;
    do @(posedge clk_i); while (!in_ready);
  endtask

  // sender pauses until every result is back and the block has gone quiet
  task automatic wait_idle();
    @(negedge clk_i);
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [RegIdxW-1:0] idx, logic [LimW-1:0] val);
    @(negedge clk_i);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk_i);
    cfg_we <= 1'b0;
  endtask

  task automatic set_limits(int main_l, int entry_l, int ghost_l);
    wait_idle();
    write_reg(REG_MAIN_LIMIT, LimW'(main_l));
    write_reg(REG_ENTRY_LIMIT, LimW'(entry_l));
    write_reg(REG_GHOST_LIMIT, LimW'(ghost_l));
    write_reg(REG_SPARE, LimW'($urandom));
  endtask

  // random phase: keys drawn mostly from a small pool so hits and ghosts occur
  task automatic random_phase(int n, int pool_n, bit long_hold);
    word_t k;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 99) < 85) k = keys[$urandom_range(0, pool_n - 1)];
      else k = $urandom;
      if (long_hold && i == n / 3) hold_req = 1'b1;
      send_item(logic'($urandom_range(0, 1)), k, $urandom);
    end
  endtask

  initial begin
    in_valid <= 1'b0;
    opcode <= OP_GET;
    req_key <= '0;
    req_value <= '0;
    cfg_we <= 1'b0;
    cfg_index <= REG_MAIN_LIMIT;
    cfg_data <= '0;
    hold_req = 1'b0;
    rst_ni <= 1'b0;
    keys[0] = 32'h0000_0000;
    keys[1] = 32'hFFFF_FFFF;
    keys[2] = 32'h8000_0000;
    keys[3] = 32'h7FFF_FFFF;
    for (int i = 4; i < KeyPool; i++) keys[i] = $urandom;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed, reset limits: main 8, fifo 4, ghost 8
    send_item(OP_GET, keys[0], 32'h1234_5678);           // absent
    send_item(OP_PUT, keys[0], 32'h8000_0000);           // new
    send_item(OP_GET, keys[0], 32'h0);                   // fifo hit
    send_item(OP_PUT, keys[0], 32'h7FFF_FFFF);           // fifo value replaced
    send_item(OP_PUT, keys[1], 32'hFFFF_FFFF);
    send_item(OP_PUT, keys[2], 32'h0);
    send_item(OP_PUT, keys[3], 32'h5A5A_A5A5);
    send_item(OP_PUT, keys[4], 32'hA5A5_5A5A);           // fifo overflow, key 0 to ghost
    send_item(OP_GET, keys[0], 32'h0);                   // ghost miss
    send_item(OP_PUT, keys[0], 32'hDEAD_BEEF);           // promote
    send_item(OP_GET, keys[0], 32'h0);                   // main hit
    send_item(OP_PUT, keys[0], 32'h0000_0001);           // main value replaced
    send_item(OP_GET, keys[3], 32'h0);                   // fifo hit, extreme key
    send_item(OP_GET, keys[2], 32'h0);
    send_item(OP_GET, 32'h0BAD_F00D, 32'hFFFF_FFFF);     // absent

    // small main queue so a promotion evicts its least recent entry
    set_limits(1, 1, 16);
    send_item(OP_PUT, keys[5], 32'h11);                  // evicts from fifo
    send_item(OP_PUT, keys[1], 32'h22);                  // ghost key promoted
    send_item(OP_PUT, keys[2], 32'h33);                  // fifo hit, value replaced
    send_item(OP_GET, keys[0], 32'h0);                   // gone from main
    send_item(OP_GET, keys[2], 32'h0);

    random_phase(60, 12, 1'b0);
    set_limits(16, 16, 16);
    random_phase(70, KeyPool, 1'b1);
    // lowered below current occupancy
    set_limits(2, 2, 2);
    random_phase(60, 12, 1'b0);
    set_limits(0, 0, 0);
    random_phase(50, 8, 1'b0);
    // out of range values saturate at the depth
    set_limits(31, 31, 31);
    random_phase(80, KeyPool, 1'b0);
    set_limits(5, 3, 4);
    random_phase(60, 14, 1'b0);
    set_limits(16, 1, 16);
    random_phase(50, 30, 1'b0);

    wait_idle();
    if (fail_count == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule

// ===== files.f =====
src/tqc_pkg.sv
src/tqc_core.sv
src/two_queue_cache_controller_top.sv
sim/tqc_checker.sv
sim/tb_two_queue_cache_controller_top.sv
